// ===== rtl/core/bch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_pkg
// shared types, constants and helpers of the conversion histogram
// ----------------------------------------------------------------------------
package bch_pkg;

    localparam int BIN_COUNT   = 1024;
    localparam int COUNT_WIDTH = 32;

    localparam int OFFSET_W    = 10;
    localparam int CHAR_W      = 8;
    localparam int OUT_FIELD_W = 32;
    localparam int SLOT_COUNT  = 6;
    localparam int SLOT_W      = 3;
    localparam int OUT_W       = (SLOT_COUNT + 1) * OUT_FIELD_W;
    localparam int IN_DATA_W   = 40;

    localparam int BIN_ADDR_W  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int BIN_IDX_W   = ((OFFSET_W > BIN_ADDR_W) ? OFFSET_W : BIN_ADDR_W) + 1;

    typedef logic [COUNT_WIDTH-1:0]                  cnt_t;
    typedef logic [SLOT_COUNT-1:0][COUNT_WIDTH-1:0]  row_t;
    typedef logic [BIN_ADDR_W-1:0]                   bin_addr_t;

    localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

    // opcodes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // strands
    localparam logic STRAND_POS = 1'b0;
    localparam logic STRAND_NEG = 1'b1;

    // counter kinds within one strand, and the first negative slot
    localparam logic [SLOT_W-1:0] KIND_UNCONV = 3'd0;
    localparam logic [SLOT_W-1:0] KIND_CONV   = 3'd1;
    localparam logic [SLOT_W-1:0] KIND_ERR    = 3'd2;
    localparam logic [SLOT_W-1:0] NEG_BASE    = 3'd3;

    // ascii characters
    localparam logic [CHAR_W-1:0] CH_C       = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G       = 8'h47;
    localparam logic [CHAR_W-1:0] CH_N       = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_T       = 8'h54;
    localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic              opcode;
        logic              strand;
        logic [OFFSET_W-1:0] read_offset;
        logic [CHAR_W-1:0] ref_base;
        logic [CHAR_W-1:0] neighbour_base;
        logic              neighbour_present;
        logic              past_end;
        logic [CHAR_W-1:0] read_base;
    } in_item_t;

    typedef struct packed {
        logic              is_read;
        logic              overhang;
        logic              bump;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
        bin_addr_t         addr;
    } dec_t;

    typedef struct packed {
        logic      we;
        bin_addr_t addr;
        row_t      data;
    } mem_wr_t;

    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] r;
        r = ch;
        if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
            r = ch - CASE_DELTA;
        return r;
    endfunction

    function automatic logic [OUT_FIELD_W-1:0] clip_out(input cnt_t v);
        logic [OUT_FIELD_W-1:0] r;
        if (v > cnt_t'({OUT_FIELD_W{1'b1}}))
            r = {OUT_FIELD_W{1'b1}};
        else
            r = OUT_FIELD_W'(v);
        return r;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        r = (v == CNT_MAX) ? v : v + cnt_t'(1);
        return r;
    endfunction

endpackage

// ===== rtl/core/bisulfite_conversion_histogram_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisulfite_conversion_histogram_top
// per-offset bisulfite conversion counters for positive and negative strand
// ----------------------------------------------------------------------------
// Each input word is either a count word (one aligned base) or a read word
// (report one bin). The block takes one word per cycle unless it stalls: a
// word passes through the input stage (decode, bin row read issued) and then
// the update stage (saturating bump written back, or read result loaded into
// the output register), so a read result is registered as its word leaves
// the update stage. The row memory has one read port and one write port, used
// once each per cycle; back-to-back words to the same bin are served by
// forwarding the last written row. Apart from the clear sweep, input stalls
// only while a read word in the update stage meets an output register that
// holds a result not yet taken. After reset the bin memory is swept to zero,
// one row per cycle; s_tready stays low meanwhile, though cfg writes are taken.
// ----------------------------------------------------------------------------
module bisulfite_conversion_histogram_top import bch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // config: include_cpg_sites
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,

    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tuser: opcode
    input  logic                 s_tuser,
    // tdata from bit 0: strand, read_offset[10], ref_base[8], neighbour_base[8],
    // neighbour_present, past_end, read_base[8], zero pad
    input  logic [IN_DATA_W-1:0] s_tdata,

    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: unconverted_pos, converted_pos, error_pos,
    // unconverted_neg, converted_neg, error_neg, overhang_total (32 each)
    output logic [OUT_W-1:0]     m_tdata
);

    // config register
    logic include_cpg_reg;

    // input stage
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    in_item_t in_item;
    dec_t     s1_dec;

    // update stage
    logic s2_valid_reg;
    dec_t s2_dec_reg;

    // forwarding of the last row written
    logic      wb_valid_reg;
    bin_addr_t wb_addr_reg;
    row_t      wb_data_reg;

    // counters and results
    cnt_t             overhang_reg;
    cnt_t             overhang_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    row_t             rd_row;
    row_t             old_row;
    row_t             new_row;
    logic [OUT_W-1:0] result;
    mem_wr_t          wr;
    logic             clearing;
    logic             adv;
    logic             accept;
    logic             s2_read;

    // unpack the input word
    always_comb
    begin
        in_item.opcode            = s_tuser;
        in_item.strand            = s_tdata[0];
        in_item.read_offset       = s_tdata[10:1];
        in_item.ref_base          = s_tdata[18:11];
        in_item.neighbour_base    = s_tdata[26:19];
        in_item.neighbour_present = s_tdata[27];
        in_item.past_end          = s_tdata[28];
        in_item.read_base         = s_tdata[36:29];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            include_cpg_reg <= 1'b0;
        else if (cfg_wr_en)
            include_cpg_reg <= cfg_wr_data;
    end

    // pipeline moves as a whole unless a read result cannot be placed
    assign s2_read  = s2_valid_reg && s2_dec_reg.is_read;
    assign adv      = !s2_read || !out_valid_reg || m_tready;
    assign s_tready = adv && !clearing;
    assign accept   = s_tvalid && s_tready;

    bch_decode u_decode
    (
        .include_cpg (include_cpg_reg),
        .item        (s1_item_reg),
        .dec         (s1_dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= in_item;
        if (adv)
            s2_dec_reg <= s1_dec;
    end

    // row memory, read issued as the word leaves the input stage
    bch_bin_mem u_bin_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_en    (adv),
        .rd_addr  (s1_dec.addr),
        .rd_data  (rd_row),
        .clearing (clearing)
    );

    // the row written on the last advance is newer than the memory read
    assign old_row = (wb_valid_reg && wb_addr_reg == s2_dec_reg.addr) ? wb_data_reg : rd_row;

    bch_update u_update
    (
        .dec      (s2_dec_reg),
        .old_row  (old_row),
        .overhang (overhang_reg),
        .new_row  (new_row),
        .result   (result)
    );

    always_comb
    begin
        wr.we   = adv && s2_valid_reg && s2_dec_reg.bump && s2_dec_reg.in_range;
        wr.addr = s2_dec_reg.addr;
        wr.data = new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else if (adv)
            wb_valid_reg <= wr.we;
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            wb_addr_reg <= wr.addr;
            wb_data_reg <= wr.data;
        end
    end

    // overhang counter, bumped in order with the bin updates
    assign overhang_next = (adv && s2_valid_reg && s2_dec_reg.overhang)
                         ? sat_inc(overhang_reg) : overhang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            overhang_reg <= '0;
        else
            overhang_reg <= overhang_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && s2_read)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_read)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/bch_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_decode
// classifies one word: qualifying site, counter slot, overhang, bin address
// ----------------------------------------------------------------------------
module bch_decode import bch_pkg::*;
(
    input  logic     include_cpg,
    input  in_item_t item,
    output dec_t     dec
);

    logic [CHAR_W-1:0]    ref_u;
    logic [CHAR_W-1:0]    nb_u;
    logic [CHAR_W-1:0]    rd_u;
    logic                 qualifies;
    logic [SLOT_W-1:0]    kind;
    logic                 known;
    logic [BIN_IDX_W-1:0] idx;

    always_comb
    begin
        ref_u = upcase(item.ref_base);
        nb_u  = upcase(item.neighbour_base);
        rd_u  = upcase(item.read_base);

        if (item.strand == STRAND_POS)
            qualifies = (ref_u == CH_C) &&
                        (!item.neighbour_present || nb_u != CH_G || include_cpg);
        else
            qualifies = (ref_u == CH_G) &&
                        (!item.neighbour_present || nb_u != CH_C || include_cpg);

        known = 1'b1;
        if (rd_u == CH_C)
            kind = KIND_UNCONV;
        else if (rd_u == CH_T)
            kind = KIND_CONV;
        else
        begin
            kind  = KIND_ERR;
            known = (rd_u != CH_N);
        end

        idx = BIN_IDX_W'(item.read_offset);

        dec.is_read  = (item.opcode == OP_READ);
        dec.overhang = (item.opcode == OP_COUNT) && item.past_end;
        dec.in_range = (idx < BIN_IDX_W'(BIN_COUNT));
        dec.addr     = idx[BIN_ADDR_W-1:0];
        dec.slot     = (item.strand == STRAND_NEG) ? kind + NEG_BASE : kind;
        dec.bump     = (item.opcode == OP_COUNT) && !item.past_end && qualifies && known;
    end

endmodule

// ===== rtl/core/bch_bin_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_bin_mem
// bin counter rows, one write and one registered read a cycle, clear sweep
// ----------------------------------------------------------------------------
module bch_bin_mem import bch_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mem_wr_t   wr,
    input  logic      rd_en,
    input  bin_addr_t rd_addr,
    output row_t      rd_data,
    output logic      clearing
);

    row_t      mem [BIN_COUNT];
    row_t      rd_data_reg;
    logic      clearing_reg;
    bin_addr_t clear_addr_reg;
    mem_wr_t   port;

    // clear sweep after reset, one row a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == bin_addr_t'(BIN_COUNT - 1))
                clearing_reg <= 1'b0;
            else
                clear_addr_reg <= clear_addr_reg + bin_addr_t'(1);
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            port.we   = 1'b1;
            port.addr = clear_addr_reg;
            port.data = '0;
        end
        else
            port = wr;
    end

    always_ff @(posedge clk)
    begin
        if (port.we)
            mem[port.addr] <= port.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// ===== rtl/core/bch_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bch_update
// saturating bump of one counter slot and read-out packing
// ----------------------------------------------------------------------------
module bch_update import bch_pkg::*;
(
    input  dec_t             dec,
    input  row_t             old_row,
    input  cnt_t             overhang,
    output row_t             new_row,
    output logic [OUT_W-1:0] result
);

    always_comb
    begin
        new_row = old_row;
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            if (dec.slot == SLOT_W'(j))
                new_row[j] = sat_inc(old_row[j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
            result[j*OUT_FIELD_W +: OUT_FIELD_W] =
                dec.in_range ? clip_out(old_row[j]) : '0;
        result[SLOT_COUNT*OUT_FIELD_W +: OUT_FIELD_W] = clip_out(overhang);
    end

endmodule

// ===== dv/tb_bisulfite_conversion_histogram_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bisulfite_conversion_histogram_top
// self-checking bench for the per-offset bisulfite conversion histogram
// ----------------------------------------------------------------------------
// A scoreboard model keeps its own bin counters and overhang count. It is
// updated as each word is taken by the dut. A read word pushes the bin
// report it should produce, and every result word is checked field by field
// against the oldest pending report. The run has a directed pass for the
// qualifying rules (CpG context, chromosome edges, case folding, past the
// chromosome end), then random traffic on a few hot bins, under both
// include_cpg_sites settings, with random gaps on input and output but in the last phase.
// ----------------------------------------------------------------------------
module tb_bisulfite_conversion_histogram_top;

    import bch_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int DRAIN_CYCLES = 4;        // two-stage pipe plus margin
    localparam int PHASE_WORDS  = 105;      // random words per phase
    localparam int RAND_PHASES  = 5;
    localparam int TIMEOUT_NS   = 400_000;  // watchdog limit in ns

    // one bin report, field k at bits [32k +: 32], same order as m_tdata
    typedef logic [SLOT_COUNT:0][OUT_FIELD_W-1:0] report_t;

    localparam int OVERHANG_IDX = SLOT_COUNT;

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic                 s_tuser     = OP_COUNT;
    logic [IN_DATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    always #(CLK_PERIOD / 2) clk = ~clk;

    bisulfite_conversion_histogram_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // ------------------------------------------------------------------------
    // scoreboard state
    // ------------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] strand_bins [SLOT_COUNT][BIN_COUNT];
    logic [COUNT_WIDTH-1:0] overhang_seen;
    logic                   cpg_sites;

    in_item_t words_to_send [$];   // filled by the stimulus block
    report_t  pending_reports [$]; // bin reports still owed by the dut
    in_item_t word_on_bus;

    bit quiet_tail = 1'b0;         // no idling on either side once set
    int gap_left   = 0;
    int stall_left = 0;
    int fail_count = 0;

    // run statistics for the closing summary
    int n_count_words = 0;
    int n_read_words  = 0;
    int n_overhang    = 0;
    int n_results     = 0;
    int n_cfg_writes  = 0;

    string field_names [SLOT_COUNT+1] = '{"unconverted_pos", "converted_pos",
        "error_pos", "unconverted_neg", "converted_neg", "error_neg",
        "overhang_total"};

    report_t got_report;
    report_t want_report;

    // ------------------------------------------------------------------------
    // scoreboard model
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] r;
        r = ch;
        if (ch >= "a" && ch <= "z")
            r = ch - 8'd32;
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == '1) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

    // apply one accepted word; a read word queues the report it must return
    task automatic tally_word(input in_item_t w);
        logic [CHAR_W-1:0] ref_ch;
        logic [CHAR_W-1:0] nb_ch;
        logic [CHAR_W-1:0] rd_ch;
        logic              qualifies;
        int                base;
        report_t           rep;
        ref_ch = fold_case(w.ref_base);
        nb_ch  = fold_case(w.neighbour_base);
        rd_ch  = fold_case(w.read_base);
        base   = (w.strand == STRAND_NEG) ? int'(NEG_BASE) : 0;
        if (w.opcode == OP_READ)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
                rep[k] = strand_bins[k][w.read_offset];
            rep[OVERHANG_IDX] = overhang_seen;
            pending_reports.push_back(rep);
            n_read_words++;
        end
        else if (w.past_end)
        begin
            // beyond the chromosome end: overhang only, bases ignored
            overhang_seen = bump(overhang_seen);
            n_count_words++;
            n_overhang++;
        end
        else
        begin
            n_count_words++;
            if (w.strand == STRAND_POS)
                qualifies = (ref_ch == CH_C) &&
                            (!w.neighbour_present || nb_ch != CH_G || cpg_sites);
            else
                qualifies = (ref_ch == CH_G) &&
                            (!w.neighbour_present || nb_ch != CH_C || cpg_sites);
            if (qualifies)
            begin
                if (rd_ch == CH_C)
                    strand_bins[base + KIND_UNCONV][w.read_offset] =
                        bump(strand_bins[base + KIND_UNCONV][w.read_offset]);
                else if (rd_ch == CH_T)
                    strand_bins[base + KIND_CONV][w.read_offset] =
                        bump(strand_bins[base + KIND_CONV][w.read_offset]);
                else if (rd_ch != CH_N)
                    strand_bins[base + KIND_ERR][w.read_offset] =
                        bump(strand_bins[base + KIND_ERR][w.read_offset]);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------
    function automatic in_item_t make_word(input logic op, input logic strand,
                                           input int offset,
                                           input logic [CHAR_W-1:0] ref_ch,
                                           input logic [CHAR_W-1:0] nb_ch,
                                           input int present, input int past,
                                           input logic [CHAR_W-1:0] rd_ch);
        in_item_t w;
        w.opcode            = op;
        w.strand            = strand;
        w.read_offset       = offset[OFFSET_W-1:0];
        w.ref_base          = ref_ch;
        w.neighbour_base    = nb_ch;
        w.neighbour_present = present[0];
        w.past_end          = past[0];
        w.read_base         = rd_ch;
        return w;
    endfunction

    // tdata from bit 0: strand, offset, ref, neighbour, present, past_end, read
    function automatic logic [IN_DATA_W-1:0] pack_word(input in_item_t w);
        return IN_DATA_W'({w.read_base, w.past_end, w.neighbour_present,
                           w.neighbour_base, w.ref_base, w.read_offset, w.strand});
    endfunction

    // mostly the bases that matter, either case, sometimes any byte
    function automatic logic [CHAR_W-1:0] pick_genome_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = CH_C;
            3, 4, 5: c = CH_G;
            6:       c = "c";
            7:       c = "g";
            8:       c = ($urandom_range(0, 1) == 0) ? "A" : "t";
            default: c = CHAR_W'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_read_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: c = CH_C;
            3, 4, 5: c = CH_T;
            6:       c = "c";
            7:       c = "t";
            8:       c = ($urandom_range(0, 1) == 0) ? CH_N : "n";
            9:       c = ($urandom_range(0, 1) == 0) ? "A" : CH_G;
            default: c = CHAR_W'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // a few hot bins so counts build up and get read back
    function automatic int pick_offset();
        int off;
        case ($urandom_range(0, 7))
            0:       off = 0;
            1:       off = 1;
            2:       off = 2;
            3:       off = 511;
            4:       off = 512;
            5:       off = BIN_COUNT - 2;
            6:       off = BIN_COUNT - 1;
            default: off = $urandom_range(0, BIN_COUNT - 1);
        endcase
        return off;
    endfunction

    function automatic in_item_t random_word();
        in_item_t w;
        w.opcode            = ($urandom_range(0, 3) == 0) ? OP_READ : OP_COUNT;
        w.strand            = 1'($urandom_range(0, 1));
        w.read_offset       = OFFSET_W'(pick_offset());
        w.ref_base          = pick_genome_char();
        w.neighbour_base    = pick_genome_char();
        w.neighbour_present = ($urandom_range(0, 3) != 0);
        w.past_end          = ($urandom_range(0, 9) == 0);
        w.read_base         = pick_read_char();
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // input driver: one word per accepted handshake, random gap bursts
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= OP_COUNT;
            s_tdata  <= '0;
            gap_left = 0;
        end
        else
        begin
            // the word on the bus was taken at this edge
            if (s_tvalid && s_tready)
                tally_word(word_on_bus);
            // bus free for a new word or a gap
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet_tail && words_to_send.size() != 0 &&
                         $urandom_range(0, 6) == 0)
                begin
                    gap_left = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end
                else if (words_to_send.size() != 0)
                begin
                    word_on_bus = words_to_send.pop_front();
                    s_tuser  <= word_on_bus.opcode;
                    s_tdata  <= pack_word(word_on_bus);
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output monitor: random stall bursts, field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_report = m_tdata;
                n_results++;
                if (pending_reports.size() == 0)
                begin
                    $error("result word with no read word pending");
                    fail_count++;
                end
                else
                begin
                    want_report = pending_reports.pop_front();
                    for (int k = 0; k <= SLOT_COUNT; k++)
                    begin
                        if (got_report[k] !== want_report[k])
                        begin
                            $error("%s: expected %0d, got %0d", field_names[k],
                                   want_report[k], got_report[k]);
                            fail_count++;
                        end
                    end
                end
            end
            // random stall bursts on the output
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------------

    // hold off until every word is taken and every report returned, then
    // give the pipe time to retire trailing count words
    task automatic wait_idle();
        while (words_to_send.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cpg(input logic value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cpg_sites   = value;
        n_cfg_writes++;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        for (int s = 0; s < SLOT_COUNT; s++)
            for (int b = 0; b < BIN_COUNT; b++)
                strand_bins[s][b] = '0;
        overhang_seen = '0;
        cpg_sites     = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // register write lands during the clearing sweep
        write_cpg(1'b0);

        @(negedge clk);
        // positive strand rules, bin 0
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, "A", 1, 0, CH_C));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, "c", "t", 1, 0, "t"));
        // CpG context is skipped unless the neighbour is missing
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, CH_G, 1, 0, CH_C));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, CH_G, 0, 0, "A"));
        // read N is never counted, wrong reference base never qualifies
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, "A", 1, 0, CH_N));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_G, "A", 1, 0, CH_C));
        // negative strand rules, last bin
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_G, "A",
                                          1, 0, CH_C));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, "g", "c",
                                          0, 0, CH_T));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_G, CH_C,
                                          1, 0, CH_T));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_G, 8'hFF,
                                          1, 0, 8'hFF));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_G, "A",
                                          1, 0, "n"));
        // past the chromosome end, incl. all fields at their top value
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, "A", 1, 1, CH_C));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, 8'hFF, 8'hFF,
                                          1, 1, 8'hFF));
        // read back; other fields of a read word are don't-care
        words_to_send.push_back(make_word(OP_READ, STRAND_POS, 0, 8'h00, 8'h00, 0, 0, 8'h00));
        words_to_send.push_back(make_word(OP_READ, STRAND_NEG, BIN_COUNT - 1, 8'hFF, 8'hFF,
                                          1, 1, 8'hFF));
        words_to_send.push_back(make_word(OP_READ, STRAND_POS, 512, CH_C, CH_G, 1, 0, CH_C));
        wait_idle();

        // CpG sites counted
        write_cpg(1'b1);
        @(negedge clk);
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, CH_C, CH_G, 1, 0, CH_C));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_G, "c",
                                          1, 0, "t"));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_POS, 0, "c", "g", 1, 0, 8'h00));
        words_to_send.push_back(make_word(OP_COUNT, STRAND_NEG, BIN_COUNT - 1, CH_C, CH_G,
                                          1, 0, CH_C));
        words_to_send.push_back(make_word(OP_READ, STRAND_POS, 0, 8'h00, 8'h00, 0, 0, 8'h00));
        words_to_send.push_back(make_word(OP_READ, STRAND_NEG, BIN_COUNT - 1, 8'h00, 8'h00,
                                          0, 0, 8'h00));
        wait_idle();

        // random traffic, alternating the CpG setting, last phase at full rate
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_cpg((p % 2) == 0);
            @(negedge clk);
            if (p == RAND_PHASES - 1)
                quiet_tail = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
                words_to_send.push_back(random_word());
            wait_idle();
        end

        $display("covered %0d count words (%0d past the chromosome end) and %0d read words",
                 n_count_words, n_overhang, n_read_words);
        $display("checked %0d bin reports over %0d register writes, both CpG settings",
                 n_results, n_cfg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== bisulfite_conversion_histogram_top.f =====
rtl/core/bch_pkg.sv
rtl/core/bch_decode.sv
rtl/core/bch_bin_mem.sv
rtl/core/bch_update.sv
rtl/core/bisulfite_conversion_histogram_top.sv
dv/tb_bisulfite_conversion_histogram_top.sv
